// ===== src/cscan_pkg.sv =====
// Shared widths and types for the C-SCAN disk scheduler.
// No dependencies.
`default_nettype none
package cscan_pkg;
	localparam int TRACK_W = 16;
	localparam int DSIZE_W = 17;
	localparam int TOTAL_W = 18;
	localparam int CNT_W   = 6;
	localparam int KEY_W   = 1 + TRACK_W + CNT_W;
	localparam int OUT_DW  = 56;

	typedef logic [TRACK_W-1:0] track_t;
	typedef logic [TOTAL_W-1:0] total_t;
	typedef logic [KEY_W-1:0]   key_t;

	localparam logic CFG_START_HEAD = 1'b0;
	localparam logic CFG_DISK_SIZE  = 1'b1;
endpackage
`default_nettype wire

// ===== src/cscan_disk_scheduler_unit.sv =====
// C-SCAN disk scheduler: request memory, selection scan and result register.
// Depends on cscan_pkg.
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid/tready      tdata = request_track, tlast = batch_end
// m_axis    out  tvalid/tready      tdata = track/seek/total/wrapped/overflow, tlast = last
// cfg       in   cfg_valid/ready    cfg_index, cfg_data
//
// A request is taken while no batch is being scheduled.
// Each result comes from one scan of the request memory: count+2 candidates
// read at one per cycle from the registered read port, after which the
// chosen candidate is loaded into the output register.
// Reset clears count, flags and state; the memory itself is not cleared.
// A stalled output holds the next result until it is taken.
module cscan_disk_scheduler_unit #(
	parameter int MAX_REQUESTS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output      logic                          s_axis_tready,
	input  wire logic [15:0]                   s_axis_tdata,  // [15:0] request_track
	input  wire logic                          s_axis_tlast,  // batch_end
	output      logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [15:0] track, [31:16] seek_distance, [49:32] total_seek,
	// [50] wrapped, [51] overflow, [55:52] zero
	output      logic [cscan_pkg::OUT_DW-1:0]  m_axis_tdata,
	output      logic                          m_axis_tlast,  // last
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic                          cfg_index,
	input  wire logic [16:0]                   cfg_data
);
	import cscan_pkg::*;

	localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_REQUESTS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]         state_q;
	track_t             start_q;
	logic [DSIZE_W-1:0] dsize_q;
	logic [CNT_W-1:0]   count_q;
	logic               drop_q;
	track_t             mem [MAX_REQUESTS];
	track_t             rd_s1;
	logic [CNT_W-1:0]   j_q;
	logic               issue_q;
	logic               v_s1;
	logic [CNT_W-1:0]   idx_s1;
	key_t               best_q, last_key_q;
	logic               best_v_q, have_last_q;
	logic [CNT_W:0]     emit_cnt_q;
	track_t             head_q;
	total_t             total_q;
	logic               prev_grp_q;

	// top cylinder
	logic [DSIZE_W-1:0] dm1;
	track_t             top;
	assign dm1 = dsize_q - DSIZE_W'(1);
	always_comb begin
		if (dsize_q == '0) top = '0;
		else if (dm1[DSIZE_W-1]) top = '1;
		else top = dm1[TRACK_W-1:0];
	end

	// candidate at stage 1
	track_t cand_t;
	logic   cand_g;
	key_t   cand_key;
	logic   cand_ok;
	always_comb begin
		if (idx_s1 < count_q) begin
			cand_t = (rd_s1 > top) ? top : rd_s1;
			cand_g = cand_t < start_q;
		end else if (idx_s1 == count_q) begin
			cand_t = top;
			cand_g = 1'b0;
		end else begin
			cand_t = '0;
			cand_g = 1'b1;
		end
		cand_key = {cand_g, cand_t, idx_s1};
		cand_ok  = (!have_last_q || cand_key > last_key_q)
			&& (!best_v_q || cand_key < best_q);
	end

	// result fields from the chosen key
	track_t sel_t;
	logic   sel_g;
	track_t seek_d;
	total_t new_total;
	logic   is_last;
	logic   load_out;
	assign sel_t = best_q[KEY_W-2 -: TRACK_W];
	assign sel_g = best_q[KEY_W-1];
	always_comb begin
		if (sel_g && !prev_grp_q) begin
			seek_d    = sel_t;
			new_total = total_q + TOTAL_W'(head_q) + TOTAL_W'(sel_t);
		end else begin
			seek_d    = (head_q > sel_t) ? head_q - sel_t : sel_t - head_q;
			new_total = total_q + TOTAL_W'(seek_d);
		end
	end
	assign is_last  = emit_cnt_q == ({1'b0, count_q} + (CNT_W+1)'(1));
	assign load_out = (state_q == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

	assign s_axis_tready = state_q == ST_IDLE;
	assign cfg_ready     = 1'b1;

	// request memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready && count_q < MAX_C)
			mem[count_q[AW-1:0]] <= s_axis_tdata;
		if (j_q < MAX_C)
			rd_s1 <= mem[j_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			start_q       <= '0;
			dsize_q       <= DSIZE_W'(65536);
			count_q       <= '0;
			drop_q        <= 1'b0;
			j_q           <= '0;
			issue_q       <= 1'b0;
			v_s1          <= 1'b0;
			idx_s1        <= '0;
			best_q        <= '0;
			best_v_q      <= 1'b0;
			last_key_q    <= '0;
			have_last_q   <= 1'b0;
			emit_cnt_q    <= '0;
			head_q        <= '0;
			total_q       <= '0;
			prev_grp_q    <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tlast  <= 1'b0;
		end else begin
			// a new result loads only when the register is free or drains now
			if (load_out)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready)
				m_axis_tvalid <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == CFG_START_HEAD) start_q <= cfg_data[TRACK_W-1:0];
				else dsize_q <= cfg_data;
			end
			v_s1   <= issue_q;
			idx_s1 <= j_q;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						if (count_q < MAX_C) count_q <= count_q + CNT_W'(1);
						else drop_q <= 1'b1;
						if (s_axis_tlast) begin
							state_q     <= ST_SCAN;
							j_q         <= '0;
							issue_q     <= 1'b1;
							best_v_q    <= 1'b0;
							have_last_q <= 1'b0;
							emit_cnt_q  <= '0;
							head_q      <= start_q;
							total_q     <= '0;
							prev_grp_q  <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						if (j_q == count_q + CNT_W'(1)) issue_q <= 1'b0;
						else j_q <= j_q + CNT_W'(1);
					end
					if (v_s1) begin
						if (cand_ok) begin
							best_q   <= cand_key;
							best_v_q <= 1'b1;
						end
						if (idx_s1 == count_q + CNT_W'(1)) state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						m_axis_tlast  <= is_last;
						m_axis_tdata  <= {4'b0, drop_q, sel_g, new_total, seek_d, sel_t};
						total_q       <= new_total;
						head_q        <= sel_t;
						prev_grp_q    <= sel_g;
						last_key_q    <= best_q;
						have_last_q   <= 1'b1;
						best_v_q      <= 1'b0;
						emit_cnt_q    <= emit_cnt_q + (CNT_W+1)'(1);
						if (is_last) begin
							state_q <= ST_IDLE;
							count_q <= '0;
							drop_q  <= 1'b0;
						end else begin
							state_q <= ST_SCAN;
							j_q     <= '0;
							issue_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== dv/tb_cscan_disk_scheduler_unit.sv =====
`timescale 1ns / 100ps
// Testbench for the C-SCAN disk scheduler: request batches in, visit order out.
// Depends on cscan_pkg and cscan_disk_scheduler_unit.
`default_nettype none
module tb_cscan_disk_scheduler_unit;
	import cscan_pkg::*;

	localparam int MAXQ = 32;
	localparam int WDOG_LIMIT = 20000;

	typedef struct packed {
		logic       last;
		logic       overflow;
		logic       wrapped;
		total_t     total;
		track_t     seek;
		track_t     trk;
	} visit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;	// [15:0] request_track
	logic s_axis_tlast = 1'b0;		// batch_end
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DW-1:0] m_axis_tdata;	// track, seek, total, wrapped, overflow
	logic m_axis_tlast;			// last
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [16:0] cfg_data = '0;

	always #4 clk = ~clk;

	cscan_disk_scheduler_unit #(.MAX_REQUESTS(MAXQ)) dut (.*);

	// Scheduler shadow state
	logic [15:0] head_cfg;
	logic [16:0] dsize_cfg;
	track_t pending_reqs[$];
	logic lost_req;
	visit_t visit_queue[$];

	int errors = 0;
	int idle_cycles = 0;
	bit stall_on = 1'b0;
	int burst_left = 0;

	// Build expected visit list when a batch closes
	function automatic void schedule_batch();
		track_t upl[$], lol[$];
		logic [15:0] top, head, d;
		logic [17:0] tot;
		int n, k;
		visit_t v;
		if (dsize_cfg == 0) top = 0;
		else if (dsize_cfg - 1 > 17'hFFFF) top = 16'hFFFF;
		else top = 16'(dsize_cfg - 1);
		foreach (pending_reqs[i]) begin
			track_t t = (pending_reqs[i] > top) ? top : pending_reqs[i];
			if (t >= head_cfg) upl = {upl, t}; else lol = {lol, t};
		end
		upl = {upl, top};
		lol = {lol, 16'd0};
		upl.sort();
		lol.sort();
		n = upl.size() + lol.size();
		k = 0;
		tot = 0;
		head = head_cfg;
		foreach (upl[i]) begin
			d = (head > upl[i]) ? head - upl[i] : upl[i] - head;
			tot += d;
			v = '{last: (k == n-1), overflow: lost_req, wrapped: 1'b0,
				total: tot, seek: d, trk: upl[i]};
			visit_queue = {visit_queue, v};
			head = upl[i];
			k++;
		end
		tot += head;
		head = 0;
		foreach (lol[i]) begin
			d = lol[i] - head;
			tot += d;
			v = '{last: (k == n-1), overflow: lost_req, wrapped: 1'b1,
				total: tot, seek: d, trk: lol[i]};
			visit_queue = {visit_queue, v};
			head = lol[i];
			k++;
		end
		pending_reqs.delete();
		lost_req = 1'b0;
	endfunction

	// Result checker, receiver stall pattern and watchdog
	always @(posedge clk) begin
		visit_t got, exp_v;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{last: m_axis_tlast, overflow: m_axis_tdata[51],
					wrapped: m_axis_tdata[50], total: m_axis_tdata[49:32],
					seek: m_axis_tdata[31:16], trk: m_axis_tdata[15:0]};
				if (visit_queue.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %h", got);
				end else begin
					exp_v = visit_queue.pop_front();
					if (got !== exp_v) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %0d/%0d/%0d %b%b%b got %0d/%0d/%0d %b%b%b",
								exp_v.trk, exp_v.seek, exp_v.total, exp_v.wrapped,
								exp_v.overflow, exp_v.last, got.trk, got.seek,
								got.total, got.wrapped, got.overflow, got.last);
					end
				end
			end
			// stall pattern: alternating runs, sometimes fully open
			if ($urandom_range(0, 7) == 0) stall_on <= ~stall_on;
			m_axis_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	// One request transfer, with bursty sender gaps
	task automatic send_request(input track_t trk, input logic close);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = $urandom_range(0, 4);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= trk;
		s_axis_tlast <= close;
		do @(posedge clk); while (!s_axis_tready);
		if (pending_reqs.size() < MAXQ) pending_reqs = {pending_reqs, trk};
		else lost_req = 1'b1;
		if (close) schedule_batch();
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (visit_queue.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [16:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_START_HEAD) head_cfg = val[15:0];
		else dsize_cfg = val;
	endtask

	task automatic random_batch(input int n);
		for (int i = 0; i < n; i++) begin
			track_t t;
			case ($urandom_range(0, 5))
				0: t = 16'd0;
				1: t = 16'hFFFF;
				2: t = head_cfg;
				default: t = $urandom_range(0, 65535);
			endcase
			send_request(t, i == n-1);
		end
	endtask

	task automatic test_defaults();
		send_request(16'd0, 1'b1);
		send_request(16'hFFFF, 1'b0);
		send_request(16'h5555, 1'b0);
		send_request(16'hAAAA, 1'b1);
	endtask

	task automatic test_head_and_clamp();
		write_reg(CFG_START_HEAD, 17'd100);
		write_reg(CFG_DISK_SIZE, 17'd200);
		send_request(16'd150, 1'b0);
		send_request(16'd50, 1'b0);
		send_request(16'd50, 1'b0);
		send_request(16'd900, 1'b0);
		send_request(16'd100, 1'b1);
		write_reg(CFG_START_HEAD, 17'd500);
		send_request(16'd300, 1'b0);
		send_request(16'd0, 1'b1);
	endtask

	task automatic test_size_extremes();
		write_reg(CFG_DISK_SIZE, 17'd0);
		write_reg(CFG_START_HEAD, 17'd0);
		send_request(16'd7, 1'b1);
		write_reg(CFG_DISK_SIZE, 17'h1FFFF);
		write_reg(CFG_START_HEAD, 17'hFFFF);
		send_request(16'hFFFF, 1'b0);
		send_request(16'd1, 1'b1);
		write_reg(CFG_DISK_SIZE, 17'd1);
		send_request(16'd0, 1'b1);
	endtask

	task automatic test_overflow();
		write_reg(CFG_DISK_SIZE, 17'd65536);
		write_reg(CFG_START_HEAD, 17'd32768);
		random_batch(MAXQ + 3);
	endtask

	task automatic test_random();
		int sent = 0;
		while (sent < 170) begin
			int n;
			if ($urandom_range(0, 3) == 0) begin
				write_reg(CFG_START_HEAD, 17'($urandom_range(0, 65535)));
				write_reg(CFG_DISK_SIZE, 17'($urandom_range(0, 131071)));
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MAXQ + 1)
				: $urandom_range(1, 8);
			random_batch(n);
			sent += n;
		end
	endtask

	initial begin
		head_cfg = 16'd0;
		dsize_cfg = 17'd65536;
		lost_req = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_head_and_clamp();
		test_size_extremes();
		test_overflow();
		test_random();
		drain();
		if (errors == 0 && visit_queue.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/cscan_pkg.sv
src/cscan_disk_scheduler_unit.sv
dv/tb_cscan_disk_scheduler_unit.sv
